// ===== hdl/rtcp_cd_pkg.sv =====
// Package for the RTCP compound deframer: field widths, status codes,
// header byte positions and the item and descriptor types.
// No dependencies; every other file of the block imports it.
package rtcp_cd_pkg;

    localparam int BYTE_W              = 8;
    localparam int COUNT_W             = 5;
    localparam int LEN_W               = 18;
    localparam int OFFSET_OUT_W        = 18;
    localparam int OFFSET_WIDTH_DEFAULT = 18;

    // Version field value required in the top two bits of header byte zero.
    localparam logic [1:0] RTCP_VERSION = 2'd2;

    // Positions of the common header bytes within a packet.
    localparam logic [LEN_W-1:0] HDR_FLAGS  = LEN_W'(0);
    localparam logic [LEN_W-1:0] HDR_TYPE   = LEN_W'(1);
    localparam logic [LEN_W-1:0] HDR_LEN_HI = LEN_W'(2);
    localparam logic [LEN_W-1:0] HDR_LEN_LO = LEN_W'(3);

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_SHORT       = 2'd1,
        ST_BAD_VERSION = 2'd2,
        ST_BAD_PADDING = 2'd3
    } status_t;

    // Registered input byte as handed from the input stage to the parser.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              datagram_last;
    } stage_t;

    typedef struct packed {
        status_t                 status;
        logic [BYTE_W-1:0]       packet_type;
        logic [COUNT_W-1:0]      report_count;
        logic [LEN_W-1:0]        body_length;
        logic [OFFSET_OUT_W-1:0] packet_offset;
    } desc_t;

endpackage

// ===== hdl/rtcp_cd_ifs.sv =====
// Valid/ready channel interfaces of the RTCP compound deframer:
// the byte channel and the packet descriptor channel. Depends on rtcp_cd_pkg.
interface rtcp_cd_octet_if;
    import rtcp_cd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              datagram_last;

    modport source (output valid, output data_byte, output datagram_last, input ready);
    modport sink   (input valid, input data_byte, input datagram_last, output ready);
endinterface

interface rtcp_cd_desc_if;
    import rtcp_cd_pkg::*;

    logic                    valid;
    logic                    ready;
    status_t                 status;
    logic [BYTE_W-1:0]       packet_type;
    logic [COUNT_W-1:0]      report_count;
    logic [LEN_W-1:0]        body_length;
    logic [OFFSET_OUT_W-1:0] packet_offset;

    modport source (output valid, output status, output packet_type, output report_count,
                    output body_length, output packet_offset, input ready);
    modport sink   (input valid, input status, input packet_type, input report_count,
                    input body_length, input packet_offset, output ready);
endinterface

// ===== hdl/rtcp_cd_in_stage.sv =====
// Input register of the RTCP compound deframer: holds one byte request
// until the parser takes it. Depends on rtcp_cd_pkg and rtcp_cd_ifs.
module rtcp_cd_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    rtcp_cd_octet_if.sink        octets,
    input  logic                 take,
    output rtcp_cd_pkg::stage_t  stage
);
    import rtcp_cd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              load;

    // A new byte may enter whenever the register is empty or is being drained.
    assign octets.ready = !valid_reg || take;
    assign load         = octets.valid && octets.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= octets.data_byte;
            last_reg <= octets.datagram_last;
        end
    end

    assign stage.valid         = valid_reg;
    assign stage.data_byte     = byte_reg;
    assign stage.datagram_last = last_reg;

endmodule

// ===== hdl/rtcp_cd_parser.sv =====
// Packet parser of the RTCP compound deframer: header capture, length and
// padding checks, error skip and the descriptor result register.
// Depends on rtcp_cd_pkg and rtcp_cd_ifs.
module rtcp_cd_parser #(
    parameter int OFFSET_WIDTH = rtcp_cd_pkg::OFFSET_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rtcp_cd_pkg::stage_t stage,
    output logic                take,
    rtcp_cd_desc_if.source      descriptors
);
    import rtcp_cd_pkg::*;

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

    // Parse state.
    logic [LEN_W-1:0]        byte_in_packet_reg, byte_in_packet_next;
    logic [LEN_W-1:0]        packet_length_reg,  packet_length_next;
    logic [BYTE_W-1:0]       header_type_reg,    header_type_next;
    logic [COUNT_W-1:0]      header_count_reg,   header_count_next;
    logic                    padding_flag_reg,   padding_flag_next;
    logic                    version_bad_reg,    version_bad_next;
    logic                    skip_to_end_reg,    skip_to_end_next;
    logic [OFFSET_WIDTH-1:0] datagram_offset_reg, datagram_offset_next;
    logic [OFFSET_WIDTH-1:0] packet_start_reg,   packet_start_next;

    // Result register.
    logic  out_valid_reg, out_valid_next;
    desc_t desc_reg;

    logic                           result_valid;
    desc_t                          result;
    logic                           err;
    logic                           done;
    status_t                        err_code;
    logic [LEN_W-1:0]               len_words_x4;
    logic [LEN_W-1:0]               body_bytes;
    logic                           at_tail;
    logic [LEN_W-1:0]               pad_bytes;
    logic [OFFSET_WIDTH-1:0]        start_now;
    logic [OFFSET_WIDTH+OFFSET_OUT_W-1:0] start_wide;

    // The byte moves on once the result slot can take whatever it produces.
    assign take = stage.valid && (!out_valid_reg || descriptors.ready);

    assign len_words_x4 = {packet_length_reg[15:8], stage.data_byte, 2'b00};
    assign pad_bytes    = LEN_W'(stage.data_byte);
    assign at_tail      = ({1'b0, byte_in_packet_reg}
                           == ({1'b0, packet_length_reg} + (LEN_W+1)'(3)));
    assign start_now    = (byte_in_packet_reg == HDR_FLAGS) ? datagram_offset_reg
                                                            : packet_start_reg;
    assign start_wide   = {{OFFSET_OUT_W{1'b0}}, start_now};

    always_comb
    begin
        err        = 1'b0;
        done       = 1'b0;
        err_code   = ST_SHORT;
        body_bytes = packet_length_reg;

        packet_length_next = packet_length_reg;
        header_type_next   = header_type_reg;
        header_count_next  = header_count_reg;
        padding_flag_next  = padding_flag_reg;
        version_bad_next   = version_bad_reg;

        priority if (byte_in_packet_reg == HDR_FLAGS)
        begin
            header_count_next = stage.data_byte[COUNT_W-1:0];
            padding_flag_next = stage.data_byte[5];
            version_bad_next  = (stage.data_byte[7:6] != RTCP_VERSION);
        end
        else if (byte_in_packet_reg == HDR_TYPE)
        begin
            header_type_next = stage.data_byte;
        end
        else if (byte_in_packet_reg == HDR_LEN_HI)
        begin
            packet_length_next = {2'b00, stage.data_byte, 8'h00};
        end
        else if (byte_in_packet_reg == HDR_LEN_LO)
        begin
            packet_length_next = len_words_x4;
            body_bytes         = '0;
            if (version_bad_reg)
            begin
                err      = 1'b1;
                err_code = ST_BAD_VERSION;
            end
            else if (len_words_x4 == '0)
            begin
                if (padding_flag_reg)
                begin
                    err      = 1'b1;
                    err_code = ST_BAD_PADDING;
                end
                else
                begin
                    done = 1'b1;
                end
            end
        end
        else if (at_tail)
        begin
            // The last body byte carries the padding count when the flag is set.
            if (padding_flag_reg)
            begin
                if ((stage.data_byte == '0) || (pad_bytes > packet_length_reg))
                begin
                    err      = 1'b1;
                    err_code = ST_BAD_PADDING;
                end
                else
                begin
                    body_bytes = packet_length_reg - pad_bytes;
                end
            end
            done = !err;
        end
        else
        begin
            // Body bytes ahead of the last one only advance the index.
        end

        if (!err && !done && stage.datagram_last)
        begin
            err      = 1'b1;
            err_code = ST_SHORT;
        end
    end

    always_comb
    begin
        result_valid         = !skip_to_end_reg && (err || done);
        result.packet_offset = start_wide[OFFSET_OUT_W-1:0];
        if (err)
        begin
            result.status       = err_code;
            result.packet_type  = '0;
            result.report_count = '0;
            result.body_length  = '0;
        end
        else
        begin
            result.status       = ST_OK;
            result.packet_type  = header_type_reg;
            result.report_count = header_count_reg;
            result.body_length  = body_bytes;
        end
    end

    always_comb
    begin
        byte_in_packet_next  = byte_in_packet_reg;
        skip_to_end_next     = skip_to_end_reg;
        datagram_offset_next = datagram_offset_reg;
        packet_start_next    = start_now;

        if (stage.datagram_last)
        begin
            byte_in_packet_next  = '0;
            skip_to_end_next     = 1'b0;
            datagram_offset_next = '0;
            packet_start_next    = '0;
        end
        else if (!skip_to_end_reg)
        begin
            if (err)
            begin
                skip_to_end_next = 1'b1;
            end
            else if (done)
            begin
                byte_in_packet_next = '0;
            end
            else
            begin
                byte_in_packet_next = byte_in_packet_reg + LEN_W'(1);
            end
            if (datagram_offset_reg != OFFSET_MAX)
            begin
                datagram_offset_next = datagram_offset_reg + OFFSET_WIDTH'(1);
            end
        end
        else
        begin
            packet_start_next = packet_start_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_packet_reg  <= '0;
            packet_length_reg   <= '0;
            header_type_reg     <= '0;
            header_count_reg    <= '0;
            padding_flag_reg    <= 1'b0;
            version_bad_reg     <= 1'b0;
            skip_to_end_reg     <= 1'b0;
            datagram_offset_reg <= '0;
            packet_start_reg    <= '0;
        end
        else if (take)
        begin
            byte_in_packet_reg  <= byte_in_packet_next;
            skip_to_end_reg     <= skip_to_end_next;
            datagram_offset_reg <= datagram_offset_next;
            packet_start_reg    <= packet_start_next;
            if (stage.datagram_last)
            begin
                packet_length_reg <= '0;
                header_type_reg   <= '0;
                header_count_reg  <= '0;
                padding_flag_reg  <= 1'b0;
                version_bad_reg   <= 1'b0;
            end
            else if (!skip_to_end_reg)
            begin
                packet_length_reg <= packet_length_next;
                header_type_reg   <= header_type_next;
                header_count_reg  <= header_count_next;
                padding_flag_reg  <= padding_flag_next;
                version_bad_reg   <= version_bad_next;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = result_valid;
        end
        else if (descriptors.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && result_valid)
        begin
            desc_reg <= result;
        end
    end

    assign descriptors.valid         = out_valid_reg;
    assign descriptors.status        = desc_reg.status;
    assign descriptors.packet_type   = desc_reg.packet_type;
    assign descriptors.report_count  = desc_reg.report_count;
    assign descriptors.body_length   = desc_reg.body_length;
    assign descriptors.packet_offset = desc_reg.packet_offset;

    // Error descriptors carry only the status and the packet offset.
    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (desc_reg.status != ST_OK))
        |-> ((desc_reg.packet_type == '0) && (desc_reg.report_count == '0)
             && (desc_reg.body_length == '0)))
        else $error("error descriptor with nonzero header fields");

    // Bytes taken while skipping after an error never produce a result.
    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (take && skip_to_end_reg) |=> !out_valid_reg)
        else $error("result produced while skipping to datagram end");

    // Inside a body the byte index never passes the packet's last byte.
    a_index_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        (!skip_to_end_reg && (byte_in_packet_reg > HDR_LEN_LO))
        |-> ({1'b0, byte_in_packet_reg} <= ({1'b0, packet_length_reg} + (LEN_W+1)'(3))))
        else $error("byte index ran past the end of the packet");

    // A saturated datagram offset only leaves saturation at a datagram end.
    a_offset_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (datagram_offset_reg == OFFSET_MAX)
        |=> ((datagram_offset_reg == OFFSET_MAX) || (datagram_offset_reg == '0)))
        else $error("datagram offset wrapped");

endmodule

// ===== hdl/rtcp_compound_deframer_top.sv =====
// Top level of the RTCP compound deframer: input byte register followed by
// the packet parser with its descriptor register. Depends on rtcp_cd_pkg,
// rtcp_cd_ifs, rtcp_cd_in_stage and rtcp_cd_parser.
//
//  Channel      Dir  Request carries                               Per request
//  octets       in   data_byte, datagram_last                      one datagram byte
//  descriptors  out  status, packet_type, report_count,            zero or one per byte
//                    body_length, packet_offset
//
// A byte can be accepted every cycle unless the descriptor register is full and
// not taken; the byte that completes or fails a packet reaches the descriptor
// output through the input register, then the parse logic into the descriptor
// register. The rate is set by the single parse step between those two registers.
// Reset is asynchronous and active low; it clears the parse state and both
// valid flags, after which the first byte is taken as header byte zero.
// When the descriptor register is full and not taken, the parser holds its
// byte and the input register fills; octets.ready then drops until the
// descriptor is taken, so no request is lost or repeated.
module rtcp_compound_deframer_top #(
    parameter int OFFSET_WIDTH = rtcp_cd_pkg::OFFSET_WIDTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    rtcp_cd_octet_if.sink  octets,
    rtcp_cd_desc_if.source descriptors
);
    import rtcp_cd_pkg::*;

    stage_t stage;
    logic   take;

    // Input register: decouples byte acceptance from the parse step.
    rtcp_cd_in_stage u_in_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .octets (octets),
        .take   (take),
        .stage  (stage)
    );

    // Parser: one pass of header, length and padding logic per byte, with
    // the descriptor register on its output.
    rtcp_cd_parser #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .take        (take),
        .descriptors (descriptors)
    );

endmodule

// ===== tb/tb_rtcp_compound_deframer_top.sv =====
// Testbench for rtcp_compound_deframer_top. It feeds hand-built and random RTCP compound
// datagrams one byte per request and checks every packet descriptor against its own model.
// Depends on rtcp_cd_pkg, the channel interfaces in rtcp_cd_ifs and the block's RTL.
module tb_rtcp_compound_deframer_top;
    import rtcp_cd_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int CYCLE_LIMIT    = 100_000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PHASE_BYTES    = 150;
    localparam int MAX_REPORTS    = 10;
    localparam logic [OFFSET_OUT_W-1:0] OFFSET_MAX =
        OFFSET_OUT_W'((1 << OFFSET_WIDTH_DEFAULT) - 1);

    // Scoreboard: mirrors the parse state of the block, turns every accepted byte
    // request into the descriptor it should cause and matches descriptors in order.
    class deframer_scoreboard;
        desc_t                   expected_descs[$];
        int                      failures;
        logic [LEN_W-1:0]        byte_idx;
        logic [LEN_W-1:0]        pkt_len;
        logic [BYTE_W-1:0]       hdr_type;
        logic [COUNT_W-1:0]      hdr_count;
        logic                    pad_flag;
        logic                    version_bad;
        logic                    skipping;
        logic [OFFSET_OUT_W-1:0] byte_offset;
        logic [OFFSET_OUT_W-1:0] pkt_start;

        function new();
            failures = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            byte_idx    = '0;
            pkt_len     = '0;
            hdr_type    = '0;
            hdr_count   = '0;
            pad_flag    = 1'b0;
            version_bad = 1'b0;
            skipping    = 1'b0;
            byte_offset = '0;
            pkt_start   = '0;
        endfunction

        // Error descriptors carry only the status and the start of the failing packet.
        function desc_t error_desc(status_t code);
            desc_t d;
            d               = '0;
            d.status        = code;
            d.packet_offset = pkt_start;
            return d;
        endfunction

        function desc_t ok_desc(logic [LEN_W-1:0] blen);
            desc_t d;
            d.status        = ST_OK;
            d.packet_type   = hdr_type;
            d.report_count  = hdr_count;
            d.body_length   = blen;
            d.packet_offset = pkt_start;
            return d;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic last);
            logic [LEN_W-1:0] blen;
            logic             done;
            logic             err;
            done = 1'b0;
            err  = 1'b0;
            if (skipping)
            begin
                if (last)
                    clear_parse();
                return;
            end
            if (byte_idx == HDR_FLAGS)
            begin
                pkt_start   = byte_offset;
                hdr_count   = b[COUNT_W-1:0];
                pad_flag    = b[5];
                version_bad = (b[7:6] != RTCP_VERSION);
            end
            else if (byte_idx == HDR_TYPE)
                hdr_type = b;
            else if (byte_idx == HDR_LEN_HI)
                pkt_len = {2'b00, b, 8'h00};
            else if (byte_idx == HDR_LEN_LO)
            begin
                // Length is in 32-bit words; the body is four bytes per word.
                pkt_len = {pkt_len[15:8], b, 2'b00};
                if (version_bad)
                begin
                    expected_descs.push_back(error_desc(ST_BAD_VERSION));
                    err = 1'b1;
                end
                else if (pkt_len == '0)
                begin
                    if (pad_flag)
                    begin
                        expected_descs.push_back(error_desc(ST_BAD_PADDING));
                        err = 1'b1;
                    end
                    else
                    begin
                        expected_descs.push_back(ok_desc('0));
                        done = 1'b1;
                    end
                end
            end
            else if (byte_idx == HDR_LEN_LO + pkt_len)
            begin
                // Last body byte: with padding it holds the pad count.
                blen = pkt_len;
                if (pad_flag && (b == '0 || LEN_W'(b) > blen))
                begin
                    expected_descs.push_back(error_desc(ST_BAD_PADDING));
                    err = 1'b1;
                end
                else
                begin
                    if (pad_flag)
                        blen = blen - LEN_W'(b);
                    expected_descs.push_back(ok_desc(blen));
                    done = 1'b1;
                end
            end
            if (!err && !done && last)
            begin
                expected_descs.push_back(error_desc(ST_SHORT));
                err = 1'b1;
            end
            if (last)
            begin
                clear_parse();
                return;
            end
            if (err)
                skipping = 1'b1;
            else if (done)
                byte_idx = '0;
            else
                byte_idx = byte_idx + LEN_W'(1);
            if (byte_offset != OFFSET_MAX)
                byte_offset = byte_offset + OFFSET_OUT_W'(1);
        endfunction

        function string fmt_desc(desc_t d);
            return $sformatf("st=%0d type=%0d cnt=%0d len=%0d off=%0d", d.status,
                             d.packet_type, d.report_count, d.body_length,
                             d.packet_offset);
        endfunction

        function void report(string what, desc_t want, desc_t got);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%s: expected %s, got %s", what, fmt_desc(want), fmt_desc(got));
        endfunction

        function void check_descriptor(desc_t got);
            desc_t want;
            if (expected_descs.size() == 0)
            begin
                report("descriptor with none pending", '0, got);
                return;
            end
            want = expected_descs.pop_front();
            if (got.status !== want.status || got.packet_type !== want.packet_type ||
                got.report_count !== want.report_count ||
                got.body_length !== want.body_length ||
                got.packet_offset !== want.packet_offset)
                report("descriptor mismatch", want, got);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   bytes_sent;
    int   cycle_count;
    desc_t got_desc;

    deframer_scoreboard sb = new();

    rtcp_cd_octet_if octets_if();
    rtcp_cd_desc_if  descs_if();

    rtcp_compound_deframer_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .octets      (octets_if.sink),
        .descriptors (descs_if.source)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // The run is cut off at the cycle limit, far above the slowest
    // correct run of a few hundred byte requests under the heaviest stalls.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Descriptor receiver: stalls at random with the current idle percentage.
    always @(posedge clk)
        descs_if.ready <= ($urandom_range(99) >= rx_idle_pct);

    // Monitors sample the channels at the clock edge, before the nonblocking updates
    // of that edge land, so each request is seen exactly once.
    always @(posedge clk)
    begin
        if (rst_n && octets_if.valid && octets_if.ready)
            sb.note_byte(octets_if.data_byte, octets_if.datagram_last);
        if (rst_n && descs_if.valid && descs_if.ready)
        begin
            got_desc.status        = descs_if.status;
            got_desc.packet_type   = descs_if.packet_type;
            got_desc.report_count  = descs_if.report_count;
            got_desc.body_length   = descs_if.body_length;
            got_desc.packet_offset = descs_if.packet_offset;
            sb.check_descriptor(got_desc);
        end
    end

    // Sends one byte request. Random idle cycles come first; valid stays high
    // between back-to-back requests so it is never dropped and raised in one step.
    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            octets_if.valid <= 1'b0;
            @(posedge clk);
        end
        octets_if.valid         <= 1'b1;
        octets_if.data_byte     <= value;
        octets_if.datagram_last <= last;
        @(posedge clk);
        while (!octets_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_datagram(input logic [BYTE_W-1:0] dg[$]);
        for (int i = 0; i < dg.size(); i++)
            send_byte(dg[i], i == dg.size() - 1);
    endtask

    // Appends one packet. Mostly well formed; a flawed packet has a wrong version,
    // a bad pad count, or the padding bit set with an empty body.
    function automatic void append_packet(ref logic [BYTE_W-1:0] dg[$], input bit flawed);
        logic [1:0]  version;
        logic        padded;
        logic [15:0] words;
        int          blen;
        int          pad;
        version = RTCP_VERSION;
        padded  = ($urandom_range(99) < 30);
        words   = ($urandom_range(99) < 10) ? 16'($urandom_range(7, 24))
                                            : 16'($urandom_range(0, 6));
        blen    = int'(words) * 4;
        pad     = (blen > 0) ? int'($urandom_range(1, blen)) : 0;
        if (flawed)
        begin
            case ($urandom_range(2))
                0:
                begin
                    version = 2'($urandom_range(2));
                    if (version == RTCP_VERSION)
                        version = 2'd3;
                end
                1:
                begin
                    padded = 1'b1;
                    if (blen == 0)
                    begin
                        words = 16'd1;
                        blen  = 4;
                    end
                    pad = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(blen + 1, 255));
                end
                default:
                begin
                    padded = 1'b1;
                    words  = '0;
                    blen   = 0;
                end
            endcase
        end
        dg.push_back({version, padded, 5'($urandom())});
        dg.push_back(($urandom_range(1) == 0) ? 8'($urandom_range(200, 204)) : 8'($urandom()));
        dg.push_back(words[15:8]);
        dg.push_back(words[7:0]);
        for (int i = 0; i < blen; i++)
            dg.push_back((padded && i == blen - 1) ? 8'(pad) : 8'($urandom()));
    endfunction

    // Most datagrams are chains of well-formed packets; the rest carry a flawed
    // last packet, are cut short, have stray bytes at the end, or are pure noise.
    function automatic void build_datagram(ref logic [BYTE_W-1:0] dg[$]);
        int n_pkts;
        int shape;
        int keep;
        dg.delete();
        shape = $urandom_range(99);
        if (shape < 6)
        begin
            repeat ($urandom_range(1, 12))
                dg.push_back(8'($urandom()));
            return;
        end
        n_pkts = $urandom_range(1, 4);
        for (int p = 0; p < n_pkts; p++)
            append_packet(dg, shape < 18 && p == n_pkts - 1);
        if (shape < 30 && shape >= 18 && dg.size() > 1)
        begin
            keep = $urandom_range(1, dg.size() - 1);
            while (dg.size() > keep)
                void'(dg.pop_back());
        end
        else if (shape < 38 && shape >= 30)
        begin
            repeat ($urandom_range(1, 6))
                dg.push_back(8'($urandom()));
        end
    endfunction

    task automatic run_random_phase(input int tx_pct, input int rx_pct);
        logic [BYTE_W-1:0] dg[$];
        int                start_count;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start_count = bytes_sent;
        while (bytes_sent - start_count < PHASE_BYTES)
        begin
            build_datagram(dg);
            send_datagram(dg);
        end
    endtask

    // Holds the byte channel idle until every pending descriptor has been taken.
    task automatic wait_drained();
        octets_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_descs.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [BYTE_W-1:0] dg[$];
        rst_n                   = 1'b0;
        octets_if.valid         = 1'b0;
        octets_if.data_byte     = '0;
        octets_if.datagram_last = 1'b0;
        tx_idle_pct             = 33;
        rx_idle_pct             = 48;
        bytes_sent              = 0;
        cycle_count             = 0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // Empty packet with all count and type bits set, then a padded packet whose
        // pad count is zero; the trailing byte is ignored after the error.
        dg = '{8'h9F, 8'hFF, 8'h00, 8'h00, 8'hA0, 8'h00, 8'h00, 8'h01,
               8'h55, 8'hAA, 8'h55, 8'h00, 8'h7E};
        send_datagram(dg);
        // Datagram ending on the first header byte.
        dg = '{8'h80};
        send_datagram(dg);
        // Ends on the second header byte with a wrong version: still reported short.
        dg = '{8'h40, 8'hC8};
        send_datagram(dg);
        // All-zero header fails the version check on its fourth byte; rest skipped.
        dg = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_datagram(dg);
        // Padding bit with an empty body.
        dg = '{8'hBF, 8'hCA, 8'h00, 8'h00};
        send_datagram(dg);
        // Body of eight bytes announced, datagram ends after one.
        dg = '{8'h81, 8'hC9, 8'h00, 8'h02, 8'h12};
        send_datagram(dg);

        // Random traffic in three idling regimes, draining in between.
        run_random_phase(33, 48);
        wait_drained();
        run_random_phase(48, 33);
        wait_drained();
        run_random_phase(0, 0);

        octets_if.valid <= 1'b0;
        while (sb.expected_descs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (sb.expected_descs.size() != 0)
            sb.report("descriptor never arrived", sb.expected_descs[0], '0);

        if (sb.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
